@@ sv/pss_pkg.sv @@
package pss_pkg;

   // Voice bank and sine table size
   localparam int VOICES         = 13;
   localparam int SINE_ADDR_BITS = 10;
   localparam int SINE_DEPTH     = 1 << SINE_ADDR_BITS;

   // Field widths
   localparam int CMD_W     = 2;
   localparam int KEY_W     = 10;
   localparam int SAMPLE_W  = 32;
   localparam int PHASE_W   = 32;
   localparam int LEVEL_W   = 28;
   localparam int DECAY_W   = 16;
   localparam int SINE_W    = 16;
   localparam int VOICE_W   = 4;
   localparam int HELD_W    = 4;
   localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;

   // Shared multiplier: unsigned level times signed coefficient
   localparam int COEF_W    = DECAY_W + 1;
   localparam int PROD_W    = LEVEL_W + 1 + COEF_W;
   localparam int TERM_W    = PROD_W - (SINE_W - 1);
   localparam int ACC_RAW_W = LEVEL_W + 2 + $clog2(VOICES);
   localparam int ACC_W     = (ACC_RAW_W > SAMPLE_W) ? ACC_RAW_W : SAMPLE_W + 1;

   // Voice codes: anything at or above VOICES means no voice
   localparam logic [VOICE_W-1:0] NO_VOICE    = 4'd14;
   localparam logic [VOICE_W-1:0] VOICES_CODE = VOICE_W'(VOICES);
   localparam logic [VOICE_W-1:0] LAST_VOICE  = VOICE_W'(VOICES - 1);
   localparam logic [HELD_W-1:0]  HELD_MAX    = 4'd15;

   // Commands
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_STRIKE_LEVEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY_FACTOR = 1'd1;

   localparam logic [LEVEL_W-1:0] STRIKE_RESET = 28'hFD89D89;
   localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd65529;

   typedef struct packed {
      logic [LEVEL_W-1:0] strike_level;
      logic [DECAY_W-1:0] decay_factor;
   } cfg_type;

   // Per-voice phase step, round(f / 8000 * 2^32), C4 up to C5
   localparam logic [PHASE_W-1:0] PHASE_INC [13] = '{
      32'd140459389, 32'd148811490, 32'd157660196, 32'd167035036, 32'd176967685,
      32'd187490355, 32'd198639016, 32'd210450713, 32'd222965174, 32'd236223201,
      32'd250269892, 32'd265151417, 32'd280918242
   };

   // Scan code of each voice's key
   localparam logic [KEY_W-1:0] KEY_OF_VOICE [13] = '{
      10'h010, 10'h003, 10'h011, 10'h004, 10'h012, 10'h013, 10'h006,
      10'h014, 10'h007, 10'h015, 10'h008, 10'h016, 10'h017
   };

   // Sine table built at elaboration: Q30 Taylor series, rounded to Q1.15
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [SINE_W-1:0] sine_table_type [SINE_DEPTH];

   function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k);
      logic [31:0] u;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      u = k << (32 - SINE_ADDR_BITS);
      r = 64'(u[29:0]);
      if (u[30]) begin
         r = ONE_Q30 - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 64'd110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return u[31] ? SINE_W'(-v) : SINE_W'(v);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tab;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         tab[k] = sine_entry(32'(k));
      end
      return tab;
   endfunction

   function automatic logic is_voice(logic [VOICE_W-1:0] v);
      return v < VOICES_CODE;
   endfunction

endpackage

@@ sv/pss_csr.sv @@
module pss_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pss_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pss_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pss_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output pss_pkg::cfg_type                 cfg
);
   import pss_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic [CSR_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_STRIKE_LEVEL: cfg_in.strike_level = pwdata[LEVEL_W-1:0];
            REG_DECAY_FACTOR: cfg_in.decay_factor = pwdata[DECAY_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strike_level <= STRIKE_RESET;
         cfg_ff.decay_factor <= DECAY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_STRIKE_LEVEL: prdata = CSR_DATA_W'(cfg_ff.strike_level);
         REG_DECAY_FACTOR: prdata = CSR_DATA_W'(cfg_ff.decay_factor);
      endcase
   end

endmodule

@@ sv/pss_sine_rom.sv @@
module pss_sine_rom (
   input  logic                                 clock,
   input  logic [pss_pkg::SINE_ADDR_BITS-1:0]   rd_addr,
   output logic signed [pss_pkg::SINE_W-1:0]    rd_data
);
   import pss_pkg::*;

   localparam sine_table_type ROM_TABLE = build_sine_table();

   logic signed [SINE_W-1:0] rd_data_ff;

   // Registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= ROM_TABLE[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pss_mul.sv @@
module pss_mul (
   input  logic                                clock,
   input  logic [pss_pkg::LEVEL_W-1:0]         op_level,
   input  logic signed [pss_pkg::COEF_W-1:0]   op_coef,
   output logic signed [pss_pkg::PROD_W-1:0]   product
);
   import pss_pkg::*;

   logic signed [PROD_W-1:0] product_ff, product_in;

   // Unsigned level times signed coefficient, registered
   assign product_in = $signed({1'b0, op_level}) * op_coef;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ sv/polyphonic_sine_tone_synth.sv @@
// Press and release items are taken while idle and may follow back to back.
// A tick runs the 13 voices through the shared multiplier, drains it, then does one or
// two decay steps; the sample comes out as the block returns to idle to take the next
// item, which waits while an earlier sample is still stalled.
// Synchronous active-high reset: all voices silent, phases zero, no voice held,
// configuration registers at their default levels.
module polyphonic_sine_tone_synth (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pss_pkg::CMD_W-1:0]             req_command,
   input  logic [pss_pkg::KEY_W-1:0]             req_key_code,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pss_pkg::SAMPLE_W-1:0]   rsp_sample,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [pss_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [pss_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [pss_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);
   import pss_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_DRAIN,
      S_DEC_RD,
      S_DEC_MUL,
      S_DEC_WR,
      S_OUT
   } state_type;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO =
      {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

   cfg_type                     cfg;

   state_type                   state_ff, state_in;
   logic [VOICE_W-1:0]          idx_ff, idx_in;
   logic [VOICE_W-1:0]          cur_ff, cur_in;
   logic [VOICE_W-1:0]          prev_ff, prev_in;
   logic [HELD_W-1:0]           held_ff, held_in;
   logic                        dec_second_ff, dec_second_in;
   logic [VOICES-1:0]           gate_ff, gate_in;
   logic [LEVEL_W-1:0]          level_ff [VOICES];
   logic [LEVEL_W-1:0]          level_in [VOICES];
   logic [PHASE_W-1:0]          phase_ff [VOICES];
   logic [PHASE_W-1:0]          phase_in [VOICES];
   logic                        pipe1_valid_ff, pipe1_valid_in;
   logic                        pipe1_gate_ff, pipe1_gate_in;
   logic                        pipe2_valid_ff, pipe2_valid_in;
   logic                        pipe2_gate_ff, pipe2_gate_in;
   logic [LEVEL_W-1:0]          level_q_ff, level_q_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;

   logic [VIDX_W-1:0]           idx_v;
   logic [VOICE_W-1:0]          dec_target;
   logic [SINE_ADDR_BITS-1:0]   rom_addr;
   logic signed [SINE_W-1:0]    rom_data;
   logic signed [COEF_W-1:0]    mul_coef;
   logic signed [PROD_W-1:0]    product;
   logic signed [TERM_W-1:0]    term;
   logic                        key_hit;
   logic [VOICE_W-1:0]          key_voice;
   logic [HELD_W-1:0]           held_inc;
   logic [VOICE_W-1:0]          cur_press;
   logic signed [SAMPLE_W-1:0]  sat_sample;

   pss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   pss_sine_rom u_rom (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   pss_mul u_mul (
      .clock    (clock),
      .op_level (level_q_ff),
      .op_coef  (mul_coef),
      .product  (product)
   );

   // Key decode
   always_comb begin
      key_hit   = 1'b0;
      key_voice = NO_VOICE;
      for (int v = 0; v < VOICES; v++) begin
         if (req_key_code == KEY_OF_VOICE[v]) begin
            key_hit   = 1'b1;
            key_voice = VOICE_W'(v);
         end
      end
   end

   assign idx_v      = idx_ff[VIDX_W-1:0];
   assign rom_addr   = phase_ff[idx_v][PHASE_W-1 -: SINE_ADDR_BITS];
   assign dec_target = dec_second_ff ? prev_ff : cur_ff;
   assign held_inc   = (held_ff < HELD_MAX) ? held_ff + 1'b1 : held_ff;
   assign cur_press  = key_hit ? key_voice : cur_ff;
   assign term       = product[PROD_W-1:SINE_W-1];

   // Multiplier takes the decay factor in the decay step, the sine otherwise
   assign mul_coef = (state_ff == S_DEC_MUL) ? $signed({1'b0, cfg.decay_factor})
                                              : COEF_W'(rom_data);

   // Saturate the voice sum to the sample width
   always_comb begin
      priority if (acc_ff > SAT_HI) begin
         sat_sample = SAT_HI[SAMPLE_W-1:0];
      end else if (acc_ff < SAT_LO) begin
         sat_sample = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sat_sample = acc_ff[SAMPLE_W-1:0];
      end
   end

   // Sequencer and voice state
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      held_in        = held_ff;
      dec_second_in  = dec_second_ff;
      gate_in        = gate_ff;
      level_in       = level_ff;
      phase_in       = phase_ff;
      pipe1_valid_in = 1'b0;
      pipe1_gate_in  = pipe1_gate_ff;
      pipe2_valid_in = pipe1_valid_ff;
      pipe2_gate_in  = pipe1_gate_ff;
      level_q_in     = level_q_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;

      // accumulate one voice term per cycle at the end of the pipe
      if (pipe2_valid_ff && pipe2_gate_ff) begin
         acc_in = acc_ff + ACC_W'(term);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               priority case (req_command)
                  CMD_TICK: begin
                     idx_in   = '0;
                     acc_in   = '0;
                     state_in = S_SWEEP;
                  end
                  CMD_PRESS: begin
                     held_in = held_inc;
                     if (held_inc > 4'd1) begin
                        if (held_inc > 4'd2 && is_voice(prev_ff)) begin
                           gate_in[prev_ff[VIDX_W-1:0]] = 1'b0;
                        end
                        prev_in = cur_ff;
                     end else begin
                        prev_in = NO_VOICE;
                     end
                     if (key_hit) begin
                        gate_in[key_voice[VIDX_W-1:0]] = 1'b1;
                     end
                     cur_in = cur_press;
                     if (is_voice(cur_press)) begin
                        level_in[cur_press[VIDX_W-1:0]] = cfg.strike_level;
                     end
                  end
                  CMD_RELEASE: begin
                     // the released key's voice is gated off, else the current one
                     if (key_hit) begin
                        gate_in[key_voice[VIDX_W-1:0]] = 1'b0;
                     end else if (is_voice(cur_ff)) begin
                        gate_in[cur_ff[VIDX_W-1:0]] = 1'b0;
                     end
                     cur_in = prev_ff;
                     if (held_ff != '0) begin
                        held_in = held_ff - 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SWEEP: begin
            level_q_in      = level_ff[idx_v];
            pipe1_gate_in   = gate_ff[idx_v];
            pipe1_valid_in  = 1'b1;
            phase_in[idx_v] = phase_ff[idx_v] + PHASE_INC[idx_v];
            if (idx_ff == LAST_VOICE) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!pipe1_valid_ff && !pipe2_valid_ff) begin
               dec_second_in = 1'b0;
               state_in      = S_DEC_RD;
            end
         end
         S_DEC_RD: begin
            if (is_voice(dec_target)) begin
               level_q_in = level_ff[dec_target[VIDX_W-1:0]];
            end
            state_in = S_DEC_MUL;
         end
         S_DEC_MUL: begin
            state_in = S_DEC_WR;
         end
         S_DEC_WR: begin
            if (is_voice(dec_target)) begin
               level_in[dec_target[VIDX_W-1:0]] = product[LEVEL_W+DECAY_W-1:DECAY_W];
            end
            // previous voice decays too while two or more keys are held
            if (!dec_second_ff && held_ff > 4'd1) begin
               dec_second_in = 1'b1;
               state_in      = S_DEC_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat_sample;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         idx_ff         <= '0;
         cur_ff         <= NO_VOICE;
         prev_ff        <= NO_VOICE;
         held_ff        <= '0;
         dec_second_ff  <= 1'b0;
         gate_ff        <= '0;
         level_ff       <= '{default: '0};
         phase_ff       <= '{default: '0};
         pipe1_valid_ff <= 1'b0;
         pipe2_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         cur_ff         <= cur_in;
         prev_ff        <= prev_in;
         held_ff        <= held_in;
         dec_second_ff  <= dec_second_in;
         gate_ff        <= gate_in;
         level_ff       <= level_in;
         phase_ff       <= phase_in;
         pipe1_valid_ff <= pipe1_valid_in;
         pipe2_valid_ff <= pipe2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pipe1_gate_ff <= pipe1_gate_in;
      pipe2_gate_ff <= pipe2_gate_in;
      level_q_ff    <= level_q_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   assign req_stall  = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

@@ sv/pss_checker.sv @@
module pss_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [pss_pkg::CMD_W-1:0]             req_command,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [pss_pkg::SAMPLE_W-1:0]   rsp_sample
);
   import pss_pkg::*;

   // A stalled sample holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled sample changed or dropped");

   // Key items never hold the input side up
   a_key_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_command == CMD_PRESS || req_command == CMD_RELEASE) |=> !req_stall)
      else $error("key item did not finish in one cycle");

   // A tick makes the block busy as the voice sweep begins
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_TICK |=> req_stall ##1 req_stall)
      else $error("tick finished too early");

   // A new sample only comes out of tick work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("sample appeared while idle");

   // Reset leaves the block idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

bind polyphonic_sine_tone_synth pss_checker u_checker (.*);
